// ----- src/mne_pkg.sv -----
// Shared types and constants for the MIDI note event encoder.
// No dependencies; every other file in src/ imports this package.
package mne_pkg;

  localparam int DeltaW       = 32;
  localparam int KeyW         = 8;
  localparam int VelW         = 7;
  localparam int GroupW       = 7;
  // Most 7-bit groups a 32-bit delta can ever need
  localparam int MaxGroupsAll = (DeltaW + GroupW - 1) / GroupW;
  localparam int GrpCntW      = 3;
  localparam int IdxW         = 3;
  localparam int QDepth       = 2;

  localparam logic [7:0] CmdNoteOn  = 8'h90;
  localparam logic [7:0] CmdNoteOff = 8'h80;
  localparam logic [7:0] ContBit    = 8'h80;

  // Classified event, as it travels from front to back
  typedef struct packed {
    logic                 first;
    logic                 ovf;
    logic [DeltaW-1:0]    delta;
    logic [GrpCntW-1:0]   ngroups;
    logic                 note_on;
    logic [KeyW-1:0]      key_byte;
    logic [VelW-1:0]      vel;
  } evt_desc_t;

  // Queue status seen by the front and the back
  typedef struct packed {
    logic head_valid;
    logic full;
  } q_stat_t;

  // Pick 7-bit group j of the delta, group 0 least significant
  function automatic logic [GroupW-1:0] get_group(input logic [DeltaW-1:0] d,
                                                  input logic [GrpCntW-1:0] j);
    logic [GroupW-1:0] g;
    unique case (j)
      3'd0:    g = d[6:0];
      3'd1:    g = d[13:7];
      3'd2:    g = d[20:14];
      3'd3:    g = d[27:21];
      3'd4:    g = {3'b000, d[31:28]};
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

// ----- src/mne_front.sv -----
// Front end: accepts note events and classifies them into descriptors.
// Depends on mne_pkg; feeds mne_queue.
module mne_front #(
  parameter int MAX_DELTA_GROUPS = 4
) (
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    first_of_line,
  input  logic [31:0]             delta_ticks,
  input  logic signed [7:0]       note_key,
  input  logic [6:0]              velocity,
  input  mne_pkg::q_stat_t        q_stat,
  output logic                    push,
  output mne_pkg::evt_desc_t      desc
);
  import mne_pkg::*;

  localparam int EffGroups = (MAX_DELTA_GROUPS < MaxGroupsAll) ? MAX_DELTA_GROUPS
                                                                : MaxGroupsAll;
  localparam int OvfShift  = GroupW * MAX_DELTA_GROUPS;

  logic               ovf_raw;
  logic [GrpCntW-1:0] ng;
  logic               on;

  // Accept whenever the queue has room
  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

  // Flag a delta that does not fit in the allowed groups
  assign ovf_raw = (OvfShift < DeltaW) ? (|(delta_ticks >> OvfShift)) : 1'b0;

  // Count significant groups, capped at the group limit
  always_comb begin
    ng = GrpCntW'(1);
    for (int j = 1; j < MaxGroupsAll; j++) begin
      if (j < EffGroups && (delta_ticks >> (GroupW * j)) != '0) begin
        ng = GrpCntW'(j + 1);
      end
    end
  end

  // Positive key gives note-on, anything else note-off with negated key
  assign on = !note_key[7] && (note_key != '0);

  always_comb begin
    desc.first    = first_of_line;
    desc.ovf      = first_of_line && ovf_raw;
    desc.delta    = delta_ticks;
    desc.ngroups  = ng;
    desc.note_on  = on;
    desc.key_byte = on ? note_key : (8'd0 - note_key);
    desc.vel      = velocity;
  end

endmodule

// ----- src/mne_queue.sv -----
// Two-entry descriptor queue between front and back.
// Depends on mne_pkg.
module mne_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  mne_pkg::evt_desc_t  desc_in,
  input  logic                pop,
  output mne_pkg::evt_desc_t  head,
  output mne_pkg::q_stat_t    q_stat
);
  import mne_pkg::*;

  localparam int PtrW = $clog2(QDepth);

  evt_desc_t         mem [QDepth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [PtrW:0]     count;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      priority if (push && !pop) count <= count + 1'b1;
      else if (pop && !push)     count <= count - 1'b1;
    end
  end

  // Hold descriptor words
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= desc_in;
  end

  assign head              = mem[rd_ptr];
  assign q_stat.head_valid = (count != '0);
  assign q_stat.full       = (count == (PtrW+1)'(QDepth));

endmodule

// ----- src/mne_back.sv -----
// Back end: walks the head descriptor into an output register, one byte a cycle unless stalled.
// Depends on mne_pkg; reads mne_queue.
module mne_back (
  input  logic                clk,
  input  logic                rst,
  input  mne_pkg::evt_desc_t  head,
  input  mne_pkg::q_stat_t    q_stat,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                last_byte,
  output logic                too_large
);
  import mne_pkg::*;

  logic [IdxW-1:0]    idx;
  logic [IdxW:0]      dlen;
  logic [IdxW:0]      idx_w;
  logic [GrpCntW-1:0] grp_sel;
  logic               advance;
  logic [7:0]         byte_next;
  logic               last_next;

  assign advance = q_stat.head_valid && (!out_valid || out_ready);
  assign pop     = advance && last_next;

  // Delta part is the group count on a first event, one zero byte otherwise
  assign dlen    = head.first ? (IdxW+1)'(head.ngroups) : (IdxW+1)'(1);
  assign idx_w   = (IdxW+1)'(idx);
  assign grp_sel = GrpCntW'(dlen - idx_w - 1'b1);

  // Pick the byte at the current position
  always_comb begin
    byte_next = '0;
    last_next = 1'b0;
    priority if (head.ovf) begin
      last_next = 1'b1;
    end else if (idx_w < dlen) begin
      if (head.first) begin
        byte_next = {1'b0, get_group(head.delta, grp_sel)};
        if (idx_w != dlen - 1'b1) byte_next = byte_next | ContBit;
      end
    end else if (idx_w == dlen) begin
      byte_next = head.note_on ? CmdNoteOn : CmdNoteOff;
    end else if (idx_w == dlen + 1'b1) begin
      byte_next = head.key_byte;
    end else begin
      byte_next = {1'b0, head.vel};
      last_next = 1'b1;
    end
  end

  // Advance byte position, restart on each new descriptor
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (advance) begin
      idx <= last_next ? '0 : idx + 1'b1;
    end
  end

  // Hold the output word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte  <= byte_next;
      last_byte <= last_next;
      too_large <= head.ovf;
    end
  end

endmodule

// ----- src/midi_note_event_encoder_top.sv -----
// Top level of the MIDI note event encoder: front, queue and back.
// Depends on mne_pkg, mne_front, mne_queue, mne_back.
//
//  channel | signals                                         | role
//  in      | in_valid/in_ready, first_of_line, delta_ticks,  | one note event per word
//          | note_key, velocity                              |
//  out     | out_valid/out_ready, out_byte, last_byte,       | one track byte per word
//          | too_large                                       |
//
// An event yields 4 to MAX_DELTA_GROUPS+3 bytes (at most 8), one per cycle out of
// the output register unless it stalls; an overflowing delta yields one flagged byte.
// The back end's one-byte output register sets the rate, so bytes leave one by one.
// The first byte passes through the queue entry and then the output register.
// Reset clears the queue, the byte position and the output valid.
// The two-entry queue keeps accepting events while the output stalls, until it is full.
module midi_note_event_encoder_top #(
  parameter int MAX_DELTA_GROUPS = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              first_of_line,
  input  logic [31:0]       delta_ticks,
  input  logic signed [7:0] note_key,
  input  logic [6:0]        velocity,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              last_byte,
  output logic              too_large
);
  import mne_pkg::*;

  evt_desc_t desc;
  evt_desc_t head;
  q_stat_t   q_stat;
  logic      push;
  logic      pop;

  mne_front #(.MAX_DELTA_GROUPS(MAX_DELTA_GROUPS)) u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .first_of_line (first_of_line),
    .delta_ticks   (delta_ticks),
    .note_key      (note_key),
    .velocity      (velocity),
    .q_stat        (q_stat),
    .push          (push),
    .desc          (desc)
  );

  mne_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .desc_in (desc),
    .pop     (pop),
    .head    (head),
    .q_stat  (q_stat)
  );

  mne_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .last_byte (last_byte),
    .too_large (too_large)
  );

  // Overflow word is a lone zero byte that closes its event
  a_ovf_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && too_large) |-> (last_byte && out_byte == 8'h00))
    else $error("overflow word malformed");

  // An accepted event is queued on the next cycle
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    push |=> q_stat.head_valid)
    else $error("accepted event missing from queue");

  // Back never pops an empty queue
  a_no_empty_pop: assert property (@(posedge clk) disable iff (rst)
    !q_stat.head_valid |-> !pop)
    else $error("pop from empty queue");

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for midi_note_event_encoder_top: a directed table, then
// random note events, with each track byte checked against typed-in or predicted bytes.
// Depends on mne_pkg and the encoder RTL in src/.
`timescale 1ns / 1ps

module tb_top;
  import mne_pkg::*;

  localparam int DeltaGroups = 4;
  localparam int RandEvents  = 150;
  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 20;

  // One byte on the track stream
  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
    logic       ovf;
  } track_byte_t;

  // One stimulus row; nexp != 0 means the expected bytes are typed in,
  // right-aligned in exp_bytes with the first byte most significant
  typedef struct packed {
    logic        is_first;
    logic [31:0] delta;
    logic [7:0]  key;
    logic [6:0]  vel;
    logic [3:0]  nexp;
    logic        ovf;
    logic [55:0] exp_bytes;
  } note_row_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic              first_of_line;
  logic [31:0]       delta_ticks;
  logic signed [7:0] note_key;
  logic [6:0]        velocity;
  logic              out_valid;
  logic              out_ready;
  logic [7:0]        out_byte;
  logic              last_byte;
  logic              too_large;

  track_byte_t track_q [$];
  note_row_t   note_tab [$];
  int unsigned errors = 0;
  int unsigned cycle_cnt = 0;

  midi_note_event_encoder_top #(
    .MAX_DELTA_GROUPS(DeltaGroups)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .first_of_line(first_of_line),
    .delta_ticks  (delta_ticks),
    .note_key     (note_key),
    .velocity     (velocity),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .last_byte    (last_byte),
    .too_large    (too_large)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Count errors; print only the first few
  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  // Work out the track bytes one note event produces
  task automatic predict_event(input logic is_first, input logic [31:0] delta,
                               input logic [7:0] key, input logic [6:0] vel);
    logic [7:0]  pend [$];
    logic [63:0] d;
    logic [7:0]  b;
    int          ngroups;
    d = {32'b0, delta};
    // Drop the whole event on a delta that does not fit the groups
    if (is_first && (d >> (GroupW * DeltaGroups)) != 0) begin
      track_q.push_back(track_byte_t'{8'h00, 1'b1, 1'b1});
      return;
    end
    if (is_first) begin
      ngroups = 1;
      while (ngroups < DeltaGroups && (d >> (GroupW * ngroups)) != 0) ngroups++;
      for (int i = ngroups; i > 0; i--) begin
        b = {1'b0, d[GroupW*(i-1) +: GroupW]};
        if (i > 1) b = b | ContBit;
        pend.push_back(b);
      end
    end else begin
      pend.push_back(8'h00);
    end
    // Positive key is note-on; zero or negative is note-off of the negated key
    if (key != 8'h00 && !key[7]) begin
      pend.push_back(CmdNoteOn);
      pend.push_back(key);
    end else begin
      pend.push_back(CmdNoteOff);
      pend.push_back(8'h00 - key);
    end
    pend.push_back({1'b0, vel});
    for (int k = 0; k < pend.size(); k++)
      track_q.push_back(track_byte_t'{pend[k], k == pend.size() - 1, 1'b0});
  endtask

  task automatic add_row(input logic is_first, input logic [31:0] delta,
                         input logic [7:0] key, input logic [6:0] vel,
                         input logic [3:0] nexp, input logic ovf,
                         input logic [55:0] exp_bytes);
    note_tab.push_back(note_row_t'{is_first, delta, key, vel, nexp, ovf, exp_bytes});
  endtask

  // Present one word on the input channel and hold it until accepted
  task automatic send_event(input note_row_t r, input bit calm);
    while (!calm && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    first_of_line <= r.is_first;
    delta_ticks   <= r.delta;
    note_key      <= r.key;
    velocity      <= r.vel;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (r.ovf) begin
      track_q.push_back(track_byte_t'{8'h00, 1'b1, 1'b1});
    end else if (r.nexp != 0) begin
      for (int k = 0; k < r.nexp; k++)
        track_q.push_back(track_byte_t'{r.exp_bytes[8*(r.nexp-1-k) +: 8],
                                        k == r.nexp - 1, 1'b0});
    end else begin
      predict_event(r.is_first, r.delta, r.key, r.vel);
    end
    @(negedge clk);
  endtask

  // Stimulus: reset, directed table, then random lines of events
  initial begin : stimulus
    note_row_t   r;
    int unsigned line_left;
    int unsigned sh;
    rst           = 1'b1;
    in_valid      = 1'b0;
    first_of_line = 1'b0;
    delta_ticks   = '0;
    note_key      = '0;
    velocity      = '0;
    line_left     = 0;

    //      first delta          key    vel    n  ovf bytes
    add_row(1'b1, 32'd0,         8'h01, 7'd0,   4, 1'b0, 56'h00_90_01_00);
    add_row(1'b1, 32'd127,       8'h7f, 7'd127, 4, 1'b0, 56'h7f_90_7f_7f);
    add_row(1'b1, 32'd128,       8'hff, 7'd64,  5, 1'b0, 56'h81_00_80_01_40);
    add_row(1'b1, 32'd16383,     8'h00, 7'd1,   5, 1'b0, 56'hff_7f_80_00_01);
    add_row(1'b1, 32'd16384,     8'h81, 7'd5,   6, 1'b0, 56'h81_80_00_80_7f_05);
    add_row(1'b1, 32'h001f_ffff, 8'h2a, 7'd99,  0, 1'b0, '0);
    add_row(1'b1, 32'h0020_0000, 8'hd6, 7'd33,  0, 1'b0, '0);
    add_row(1'b1, 32'h0fff_ffff, 8'h40, 7'd127, 7, 1'b0, 56'hff_ff_ff_7f_90_40_7f);
    add_row(1'b1, 32'h1000_0000, 8'h01, 7'd1,   1, 1'b1, '0);
    add_row(1'b1, 32'hffff_ffff, 8'h7f, 7'd127, 1, 1'b1, '0);
    add_row(1'b0, 32'hffff_ffff, 8'h80, 7'd0,   4, 1'b0, 56'h00_80_80_00);
    add_row(1'b0, 32'd0,         8'h00, 7'd127, 4, 1'b0, 56'h00_80_00_7f);
    add_row(1'b0, 32'h1000_0000, 8'h01, 7'd1,   0, 1'b0, '0);
    add_row(1'b1, 32'd1,         8'h80, 7'd127, 0, 1'b0, '0);
    add_row(1'b1, 32'h0aaa_aaaa, 8'h55, 7'd42,  0, 1'b0, '0);
    add_row(1'b1, 32'h5555_5555, 8'haa, 7'd85,  0, 1'b0, '0);
    add_row(1'b0, 32'h1234_5678, 8'h7f, 7'd0,   0, 1'b0, '0);
    add_row(1'b1, 32'd0,         8'h00, 7'd0,   0, 1'b0, '0);
    add_row(1'b1, 32'h0000_3fff, 8'hc3, 7'd77,  0, 1'b0, '0);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (note_tab[i]) send_event(note_tab[i], 1'b0);

    // Random part: lines of one to four events, with some broken lines
    for (int n = 0; n < RandEvents; n++) begin
      if (line_left == 0) begin
        r.is_first = 1'b1;
        line_left  = $urandom_range(4, 1);
      end else begin
        r.is_first = 1'b0;
      end
      line_left--;
      if ($urandom_range(99) < 15) r.is_first = ~r.is_first;

      if (!r.is_first) begin
        r.delta = $urandom();
      end else begin
        case ($urandom_range(9))
          3:       r.delta = $urandom_range(16383, 128);
          4:       r.delta = $urandom_range(2097151, 16384);
          5:       r.delta = $urandom_range(268435455, 2097152);
          6: begin
            sh      = 7 * $urandom_range(4, 1);
            r.delta = (32'd1 << sh) - $urandom_range(1, 0);
          end
          7:       r.delta = $urandom();
          8:       r.delta = $urandom_range(32'hffff_ffff, 32'h1000_0000);
          default: r.delta = $urandom_range(127);
        endcase
      end

      if ($urandom_range(7) == 0) begin
        case ($urandom_range(4))
          0:       r.key = 8'h00;
          1:       r.key = 8'h80;
          2:       r.key = 8'h7f;
          3:       r.key = 8'h81;
          default: r.key = 8'h01;
        endcase
      end else begin
        r.key = 8'($urandom_range(255));
      end
      r.vel       = 7'($urandom_range(127));
      r.nexp      = '0;
      r.ovf       = 1'b0;
      r.exp_bytes = '0;
      send_event(r, n >= 70 && n < 110);
    end
    in_valid <= 1'b0;

    // Drain, then give the block a few more cycles to show stray bytes
    while (track_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (track_q.size() != 0)
      flag_error($sformatf("%0d expected bytes never arrived", track_q.size()));
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Stall the output side at random, with a periodic calm window free of stalls
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ((cycle_cnt % 1024) >= 600 && (cycle_cnt % 1024) < 800) ||
                   ($urandom_range(99) >= 31);
    end
  end

  // Check each accepted output word against the oldest expectation
  always @(posedge clk) begin : check_bytes
    track_byte_t want;
    track_byte_t got;
    if (!rst && out_valid && out_ready) begin
      got = track_byte_t'{out_byte, last_byte, too_large};
      if (track_q.size() == 0) begin
        flag_error($sformatf("unexpected byte %02h last=%0b too_large=%0b",
                             out_byte, last_byte, too_large));
      end else begin
        want = track_q.pop_front();
        if (got != want)
          flag_error($sformatf("byte mismatch: exp %02h/%0b/%0b got %02h/%0b/%0b",
                               want.data, want.is_last, want.ovf,
                               got.data, got.is_last, got.ovf));
      end
    end
  end

  // Hard stop on a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule

// ----- filelist.f -----
src/mne_pkg.sv
src/mne_front.sv
src/mne_queue.sv
src/mne_back.sv
src/midi_note_event_encoder_top.sv
verif/tb_top.sv
